// ----- sv/uspl_pkg.sv -----
// ----------------------------------------------------------------------------
// uspl_pkg
// Shared constants, command and status types and ring index helpers for the
// uneven-series moving average block.
// ----------------------------------------------------------------------------
package uspl_pkg;

    // ring store
    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // field widths
    localparam int T_W    = 24;
    localparam int V_W    = 24;
    localparam int AREA_W = 56;
    localparam int DEN_W  = 25;
    localparam int MA_W   = 29;
    localparam int MB_W   = 26;
    localparam int MP_W   = MA_W + MB_W;
    localparam int HALF_W = AREA_W / 2;

    // saturation limits of the average
    localparam logic signed [AREA_W-1:0] AVG_MAX = AREA_W'(64'sd8388607);
    localparam logic signed [AREA_W-1:0] AVG_MIN = AREA_W'(-64'sd8388608);

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FIRST_MUL,
        OP_FIRST_SET,
        OP_RD_NEWEST,
        OP_CAP_PREV,
        OP_OVF_DROP,
        OP_RD_LEFT,
        OP_CAP_A,
        OP_SEG_MUL,
        OP_SEG_SUB,
        OP_SEG_DROP,
        OP_WRITE_MUL,
        OP_ADD_NEW,
        OP_EDGE_CHK,
        OP_EDGE_SMUL,
        OP_EDGE_SSET,
        OP_EDGE_PCAP,
        OP_INT_MUL,
        OP_DIV_INT,
        OP_INT_Y,
        OP_EDGE_MLO,
        OP_EDGE_MHI,
        OP_EDGE_ISET,
        OP_TRIM,
        OP_DIV_AVG,
        OP_AVG_SET,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic first_item;
        logic order_err;
        logic full;
        logic oldest_is_left;
        logic walk_stop;
        logic edge_simple;
        logic dt_bad;
        logic div_done;
    } stat_t;

    // next slot, wrapping at the ring depth
    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s == IDX_W'(RING_DEPTH - 1)) r = '0;
        else r = s + 1'b1;
        return r;
    endfunction

    // slot k places back from s, k no larger than the depth
    function automatic logic [IDX_W-1:0] slot_back(input logic [IDX_W-1:0] s,
                                                   input logic [CNT_W-1:0] k);
        logic [CNT_W+1:0] x;
        x = (CNT_W+2)'(s) + (CNT_W+2)'(RING_DEPTH) - (CNT_W+2)'(k);
        if (x >= (CNT_W+2)'(RING_DEPTH)) x = x - (CNT_W+2)'(RING_DEPTH);
        return x[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/uspl_div.sv -----
// ----------------------------------------------------------------------------
// uspl_div
// Shift-subtract signed divider, one quotient bit per cycle, truncating
// toward zero. Positive divisor only.
// ----------------------------------------------------------------------------
module uspl_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [uspl_pkg::AREA_W-1:0]  num,
    input  logic        [uspl_pkg::DEN_W-1:0]   den,
    output logic                                done,
    output logic signed [uspl_pkg::AREA_W-1:0]  quo
);
    localparam int AW = uspl_pkg::AREA_W;
    localparam int DW = uspl_pkg::DEN_W;
    localparam int SW = $clog2(AW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;

    // one restoring step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, dvd_reg[AW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[AW-1];
            dvd_next  = num[AW-1] ? AW'(-num) : AW'(num);
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DW'(trial - {1'b0, den_reg});
                dvd_next = {dvd_reg[AW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                dvd_next = {dvd_reg[AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SW'(AW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? AW'(-$signed(dvd_reg)) : $signed(dvd_reg);

endmodule

// ----- sv/uspl_dp.sv -----
// ----------------------------------------------------------------------------
// uspl_dp
// Datapath: sample rings, series state, shared multiplier, divider and the
// result and output word registers.
// ----------------------------------------------------------------------------
module uspl_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [uspl_pkg::T_W-1:0]       cfg_wdata,
    input  logic [uspl_pkg::T_W-1:0]       in_time,
    input  logic [uspl_pkg::V_W-1:0]       in_value,
    input  logic                           in_start,
    input  uspl_pkg::cmd_t                 cmd,
    output uspl_pkg::stat_t                stat,
    output logic [uspl_pkg::V_W-1:0]       out_average,
    output logic [1:0]                     out_flags
);
    localparam int D  = uspl_pkg::RING_DEPTH;
    localparam int IW = uspl_pkg::IDX_W;
    localparam int CW = uspl_pkg::CNT_W;
    localparam int TW = uspl_pkg::T_W;
    localparam int VW = uspl_pkg::V_W;
    localparam int AW = uspl_pkg::AREA_W;
    localparam int HW = uspl_pkg::HALF_W;
    localparam int PW = uspl_pkg::MP_W;
    localparam int BW = uspl_pkg::MB_W;
    localparam int MW = uspl_pkg::MA_W;
    localparam int DW = uspl_pkg::DEN_W;

    // sample store
    logic [TW-1:0]        time_ring  [D];
    logic signed [VW-1:0] value_ring [D];
    logic [TW-1:0]        rd_t_reg;
    logic signed [VW-1:0] rd_v_reg;
    logic [IW-1:0]        raddr;

    // config and latched input
    logic [TW-1:0]        w_reg;
    logic [TW-1:0]        w_eff;
    logic [TW-1:0]        t_reg;
    logic signed [VW-1:0] v_reg;
    logic                 start_reg;

    // series state
    logic [IW-1:0]        head_reg, left_reg, newest_reg;
    logic [CW-1:0]        held_reg;
    logic signed [AW-1:0] area_reg, edge_reg;
    logic signed [VW-1:0] first_reg;

    // working registers
    logic [TW-1:0]        tprev_reg, ta_reg;
    logic signed [VW-1:0] vprev_reg, va_reg, vb_reg;
    logic signed [BW-1:0] tr_reg;
    logic [DW-1:0]        dt_reg;
    logic [AW-1:0]        s_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 ovf_reg;
    logic signed [VW-1:0] res_avg_reg;
    logic                 res_err_reg, res_ovf_reg;
    logic [VW-1:0]        m_data_reg;
    logic [1:0]           m_user_reg;

    // combinational helpers
    logic [IW-1:0]        oldest;
    logic signed [BW-1:0] left_edge, tr_c;
    logic signed [DW-1:0] dt_c;
    logic signed [MW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [AW-1:0] prod56, edge_i, div_num;
    logic [DW-1:0]        div_den;
    logic                 div_start, div_done;
    logic signed [AW-1:0] div_quo;
    logic [CW:0]          span, cut;

    assign w_eff     = (w_reg == '0) ? TW'(1) : w_reg;
    assign oldest    = uspl_pkg::slot_back(head_reg, held_reg);
    assign left_edge = $signed({2'b00, t_reg}) - $signed({2'b00, w_eff});
    assign tr_c      = $signed({2'b00, ta_reg}) - left_edge;
    assign dt_c      = $signed({1'b0, ta_reg}) - $signed({1'b0, rd_t_reg});
    assign prod56    = AW'(prod_reg);
    assign edge_i    = acc_reg + $signed({prod_reg[HW-1:0], {HW{1'b0}}});

    // status toward the controller
    always_comb begin
        stat.first_item     = start_reg || (held_reg == '0);
        stat.order_err      = t_reg < rd_t_reg;
        stat.full           = held_reg >= CW'(D);
        stat.oldest_is_left = oldest == left_reg;
        stat.walk_stop      = (left_reg == newest_reg) ||
                              !($signed({2'b00, rd_t_reg}) < left_edge);
        stat.edge_simple    = (left_reg == oldest) || (tr_c == '0);
        stat.dt_bad         = dt_c[DW-1] || (dt_c == '0);
        stat.div_done       = div_done;
    end

    // ring read address
    always_comb begin
        case (cmd.op)
            uspl_pkg::OP_RD_NEWEST: raddr = uspl_pkg::slot_back(head_reg, CW'(1));
            uspl_pkg::OP_CAP_A:     raddr = uspl_pkg::slot_next(left_reg);
            uspl_pkg::OP_EDGE_CHK:  raddr = uspl_pkg::slot_back(left_reg, CW'(1));
            default:                raddr = left_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            uspl_pkg::OP_FIRST_MUL: begin
                mul_a = MW'(v_reg);
                mul_b = $signed({2'b00, w_eff});
            end
            uspl_pkg::OP_SEG_MUL: begin
                mul_a = MW'($signed({va_reg[VW-1], va_reg}) +
                            $signed({rd_v_reg[VW-1], rd_v_reg}));
                mul_b = $signed({2'b00, rd_t_reg}) - $signed({2'b00, ta_reg});
            end
            uspl_pkg::OP_WRITE_MUL: begin
                mul_a = MW'($signed({v_reg[VW-1], v_reg}) +
                            $signed({vprev_reg[VW-1], vprev_reg}));
                mul_b = $signed({2'b00, t_reg}) - $signed({2'b00, tprev_reg});
            end
            uspl_pkg::OP_EDGE_SMUL: begin
                mul_a = MW'(first_reg);
                mul_b = tr_reg;
            end
            uspl_pkg::OP_INT_MUL: begin
                mul_a = MW'($signed({vb_reg[VW-1], vb_reg}) -
                            $signed({va_reg[VW-1], va_reg}));
                mul_b = tr_reg;
            end
            uspl_pkg::OP_EDGE_MLO: begin
                mul_a = $signed(MW'(s_reg[HW-1:0]));
                mul_b = tr_reg;
            end
            uspl_pkg::OP_EDGE_MHI: begin
                mul_a = MW'($signed(s_reg[AW-1:HW]));
                mul_b = tr_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider operands
    assign div_start = (cmd.op == uspl_pkg::OP_DIV_INT) || (cmd.op == uspl_pkg::OP_DIV_AVG);
    assign div_num   = (cmd.op == uspl_pkg::OP_DIV_INT) ? prod56 : area_reg;
    assign div_den   = (cmd.op == uspl_pkg::OP_DIV_INT) ? dt_reg : {w_eff, 1'b0};

    uspl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // trim distance from oldest stored sample to left sample
    always_comb begin
        if (left_reg >= oldest) span = (CW+1)'(left_reg) - (CW+1)'(oldest);
        else span = (CW+1)'(left_reg) + (CW+1)'(D) - (CW+1)'(oldest);
        cut = '0;
        if (held_reg > CW'(1) && span > (CW+1)'(1)) begin
            cut = span - (CW+1)'(1);
            if (cut > (CW+1)'(held_reg) - (CW+1)'(1))
                cut = (CW+1)'(held_reg) - (CW+1)'(1);
        end
    end

    // sample rings
    always_ff @(posedge aclk) begin
        if (cmd.op == uspl_pkg::OP_FIRST_SET) begin
            time_ring[0]  <= t_reg;
            value_ring[0] <= v_reg;
        end else if (cmd.op == uspl_pkg::OP_WRITE_MUL) begin
            time_ring[head_reg]  <= t_reg;
            value_ring[head_reg] <= v_reg;
        end
        rd_t_reg <= time_ring[raddr];
        rd_v_reg <= value_ring[raddr];
    end

    // series state and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg      <= TW'(1);
            head_reg   <= '0;
            left_reg   <= '0;
            newest_reg <= '0;
            held_reg   <= '0;
            area_reg   <= '0;
            edge_reg   <= '0;
            first_reg  <= '0;
        end else begin
            if (cfg_we) w_reg <= cfg_wdata;
            case (cmd.op)
                uspl_pkg::OP_FIRST_SET: begin
                    head_reg  <= uspl_pkg::slot_next('0);
                    left_reg  <= '0;
                    held_reg  <= CW'(1);
                    first_reg <= v_reg;
                    area_reg  <= {prod_reg, 1'b0};
                    edge_reg  <= {prod_reg, 1'b0};
                end
                uspl_pkg::OP_OVF_DROP: held_reg <= held_reg - 1'b1;
                uspl_pkg::OP_SEG_SUB: begin
                    area_reg <= area_reg - prod56;
                    left_reg <= uspl_pkg::slot_next(left_reg);
                end
                uspl_pkg::OP_SEG_DROP: begin
                    area_reg <= area_reg - prod56;
                    left_reg <= uspl_pkg::slot_next(left_reg);
                    held_reg <= held_reg - 1'b1;
                end
                uspl_pkg::OP_WRITE_MUL: begin
                    newest_reg <= head_reg;
                    head_reg   <= uspl_pkg::slot_next(head_reg);
                    held_reg   <= held_reg + 1'b1;
                end
                uspl_pkg::OP_ADD_NEW: area_reg <= area_reg + prod56 - edge_reg;
                uspl_pkg::OP_EDGE_SSET: begin
                    edge_reg <= {prod_reg, 1'b0};
                    area_reg <= area_reg + $signed({prod_reg, 1'b0});
                end
                uspl_pkg::OP_EDGE_ISET: begin
                    edge_reg <= edge_i;
                    area_reg <= area_reg + edge_i;
                end
                uspl_pkg::OP_TRIM: held_reg <= held_reg - CW'(cut);
                default: ;
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            uspl_pkg::OP_LATCH: begin
                t_reg     <= in_time;
                v_reg     <= in_value;
                start_reg <= in_start;
                ovf_reg   <= 1'b0;
            end
            uspl_pkg::OP_FIRST_SET: begin
                res_avg_reg <= v_reg;
                res_err_reg <= 1'b0;
                res_ovf_reg <= 1'b0;
            end
            uspl_pkg::OP_CAP_PREV: begin
                tprev_reg   <= rd_t_reg;
                vprev_reg   <= rd_v_reg;
                res_avg_reg <= '0;
                res_err_reg <= 1'b1;
                res_ovf_reg <= 1'b0;
            end
            uspl_pkg::OP_OVF_DROP, uspl_pkg::OP_SEG_DROP: ovf_reg <= 1'b1;
            uspl_pkg::OP_CAP_A: begin
                ta_reg <= rd_t_reg;
                va_reg <= rd_v_reg;
            end
            uspl_pkg::OP_EDGE_CHK: tr_reg <= tr_c;
            uspl_pkg::OP_EDGE_PCAP: begin
                dt_reg <= dt_c;
                vb_reg <= rd_v_reg;
            end
            uspl_pkg::OP_INT_Y: s_reg <= AW'(div_quo + $signed({AW'(va_reg), 1'b0}));
            uspl_pkg::OP_EDGE_MHI: acc_reg <= prod56;
            uspl_pkg::OP_AVG_SET: begin
                if (div_quo > uspl_pkg::AVG_MAX) res_avg_reg <= VW'(uspl_pkg::AVG_MAX);
                else if (div_quo < uspl_pkg::AVG_MIN) res_avg_reg <= VW'(uspl_pkg::AVG_MIN);
                else res_avg_reg <= div_quo[VW-1:0];
                res_err_reg <= 1'b0;
                res_ovf_reg <= ovf_reg;
            end
            uspl_pkg::OP_OUT_LOAD: begin
                m_data_reg <= res_avg_reg;
                m_user_reg <= {res_ovf_reg, res_err_reg};
            end
            default: ;
        endcase
        if (cmd.op == uspl_pkg::OP_FIRST_MUL || cmd.op == uspl_pkg::OP_SEG_MUL ||
            cmd.op == uspl_pkg::OP_WRITE_MUL || cmd.op == uspl_pkg::OP_EDGE_SMUL ||
            cmd.op == uspl_pkg::OP_INT_MUL || cmd.op == uspl_pkg::OP_EDGE_MLO ||
            cmd.op == uspl_pkg::OP_EDGE_MHI)
            prod_reg <= mul_p;
    end

    assign out_average = m_data_reg;
    assign out_flags   = m_user_reg;

endmodule

// ----- sv/uspl_ctrl.sv -----
// ----------------------------------------------------------------------------
// uspl_ctrl
// Sequencer: accepts a word, steps the datapath through the update, the left
// edge walk and the divisions it needs, and hands the result to the output register.
// ----------------------------------------------------------------------------
module uspl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  uspl_pkg::stat_t stat,
    output uspl_pkg::cmd_t  cmd
);
    typedef enum logic [27:0] {
        S_IDLE = 28'd1 << 0,  S_CHK0 = 28'd1 << 1,  S_FMUL = 28'd1 << 2,
        S_FSET = 28'd1 << 3,  S_PREV = 28'd1 << 4,  S_DROP = 28'd1 << 5,
        S_SA   = 28'd1 << 6,  S_SB   = 28'd1 << 7,  S_SC   = 28'd1 << 8,
        S_SS   = 28'd1 << 9,  S_WMUL = 28'd1 << 10, S_ADDN = 28'd1 << 11,
        S_EDGE = 28'd1 << 12, S_ESM  = 28'd1 << 13, S_ESS  = 28'd1 << 14,
        S_EP   = 28'd1 << 15, S_EIM  = 28'd1 << 16, S_EDIV = 28'd1 << 17,
        S_EDW  = 28'd1 << 18, S_EY   = 28'd1 << 19, S_ELO  = 28'd1 << 20,
        S_EHI  = 28'd1 << 21, S_ESUM = 28'd1 << 22, S_TRIM = 28'd1 << 23,
        S_ADIV = 28'd1 << 24, S_ADW  = 28'd1 << 25, S_AVG  = 28'd1 << 26,
        S_DONE = 28'd1 << 27
    } state_t;

    state_t state_reg, state_next;
    logic   walk_reg, walk_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;

    // next state and command
    always_comb begin
        state_next  = state_reg;
        walk_next   = walk_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd.op      = uspl_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = uspl_pkg::OP_LATCH;
                    state_next = S_CHK0;
                end
            end
            S_CHK0: begin
                cmd.op     = uspl_pkg::OP_RD_NEWEST;
                state_next = stat.first_item ? S_FMUL : S_PREV;
            end
            S_FMUL: begin
                cmd.op     = uspl_pkg::OP_FIRST_MUL;
                state_next = S_FSET;
            end
            S_FSET: begin
                cmd.op     = uspl_pkg::OP_FIRST_SET;
                state_next = S_DONE;
            end
            S_PREV: begin
                cmd.op = uspl_pkg::OP_CAP_PREV;
                if (stat.order_err) state_next = S_DONE;
                else if (stat.full && stat.oldest_is_left) begin
                    walk_next  = 1'b0;
                    state_next = S_SA;
                end else if (stat.full) state_next = S_DROP;
                else state_next = S_WMUL;
            end
            S_DROP: begin
                cmd.op     = uspl_pkg::OP_OVF_DROP;
                state_next = S_WMUL;
            end
            // one segment of the left edge: read left, read its successor
            S_SA: begin
                cmd.op     = uspl_pkg::OP_RD_LEFT;
                state_next = S_SB;
            end
            S_SB: begin
                cmd.op     = uspl_pkg::OP_CAP_A;
                state_next = (walk_reg && stat.walk_stop) ? S_EDGE : S_SC;
            end
            S_SC: begin
                cmd.op     = uspl_pkg::OP_SEG_MUL;
                state_next = S_SS;
            end
            S_SS: begin
                cmd.op     = walk_reg ? uspl_pkg::OP_SEG_SUB : uspl_pkg::OP_SEG_DROP;
                state_next = walk_reg ? S_SA : S_WMUL;
            end
            S_WMUL: begin
                cmd.op     = uspl_pkg::OP_WRITE_MUL;
                state_next = S_ADDN;
            end
            S_ADDN: begin
                cmd.op     = uspl_pkg::OP_ADD_NEW;
                walk_next  = 1'b1;
                state_next = S_SA;
            end
            // partial area left of the left sample
            S_EDGE: begin
                cmd.op     = uspl_pkg::OP_EDGE_CHK;
                state_next = stat.edge_simple ? S_ESM : S_EP;
            end
            S_ESM: begin
                cmd.op     = uspl_pkg::OP_EDGE_SMUL;
                state_next = S_ESS;
            end
            S_ESS: begin
                cmd.op     = uspl_pkg::OP_EDGE_SSET;
                state_next = S_TRIM;
            end
            S_EP: begin
                cmd.op     = uspl_pkg::OP_EDGE_PCAP;
                state_next = stat.dt_bad ? S_ESM : S_EIM;
            end
            S_EIM: begin
                cmd.op     = uspl_pkg::OP_INT_MUL;
                state_next = S_EDIV;
            end
            S_EDIV: begin
                cmd.op     = uspl_pkg::OP_DIV_INT;
                state_next = S_EDW;
            end
            S_EDW: begin
                if (stat.div_done) state_next = S_EY;
            end
            S_EY: begin
                cmd.op     = uspl_pkg::OP_INT_Y;
                state_next = S_ELO;
            end
            S_ELO: begin
                cmd.op     = uspl_pkg::OP_EDGE_MLO;
                state_next = S_EHI;
            end
            S_EHI: begin
                cmd.op     = uspl_pkg::OP_EDGE_MHI;
                state_next = S_ESUM;
            end
            S_ESUM: begin
                cmd.op     = uspl_pkg::OP_EDGE_ISET;
                state_next = S_TRIM;
            end
            S_TRIM: begin
                cmd.op     = uspl_pkg::OP_TRIM;
                state_next = S_ADIV;
            end
            S_ADIV: begin
                cmd.op     = uspl_pkg::OP_DIV_AVG;
                state_next = S_ADW;
            end
            S_ADW: begin
                if (stat.div_done) state_next = S_AVG;
            end
            S_AVG: begin
                cmd.op     = uspl_pkg::OP_AVG_SET;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op      = uspl_pkg::OP_OUT_LOAD;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            walk_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            walk_reg   <= walk_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ----- sv/uneven_sma_linear_interp.sv -----
// ----------------------------------------------------------------------------
// uneven_sma_linear_interp
// Trailing time-window average of an unevenly spaced, linearly interpolated
// series.
// ----------------------------------------------------------------------------
// One word in, one word out. A series start and a sample with a backwards
// time skip the edge walk and the divisions. Any other sample walks the left
// window edge over every stored sample it passes, and its time is set by the
// 56-step shift-subtract divider, run once for the edge value when the left
// edge falls between two samples and needs interpolation and once for the
// average, and by the single read port of the sample ring, through which
// the edge walk reads each sample. A finished result waits in the output
// register while the next word is taken in.
module uneven_sma_linear_interp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,   // window_width
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // sample_time [23:0], sample_value [47:24]
    input  logic        s_tuser,     // series_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // average [23:0]
    output logic [1:0]  m_tuser      // order_error [0], ring_overflow [1]
);
    uspl_pkg::cmd_t  cmd;
    uspl_pkg::stat_t stat;

    uspl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uspl_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_time     (s_tdata[23:0]),
        .in_value    (s_tdata[47:24]),
        .in_start    (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .out_average (m_tdata),
        .out_flags   (m_tuser)
    );

    // one word at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while previous still in progress");

    // a backwards time gives a zero average and no overflow flag
    a_order_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 24'd0) && !m_tuser[1])
        else $error("order error result carries data");

endmodule
